>>> rtl/core/binary_image_block_representation_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the block representation core
// Checks are sampled on i_clk and switched off while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef BINARY_IMAGE_BLOCK_REPRESENTATION_MACROS_SVH
`define BINARY_IMAGE_BLOCK_REPRESENTATION_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define BIBR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bibr check failed");

// Consequent must hold in the cycle after the antecedent
`define BIBR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bibr check failed");

`endif

>>> rtl/core/bibr_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bibr_pkg
// Shared types and constants for the block representation core.
// ---------------------------------------------------------------------------
package bibr_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_MAX_RUNS   = 512;

    localparam int CFG_W     = 11;
    localparam int FIELD_W   = 10;
    localparam int PIXEL_W   = 8;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 3;

    // register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] RST_WIDTH  = CFG_W'(1024);
    localparam logic [CFG_W-1:0] RST_HEIGHT = CFG_W'(1024);

    // control from the handshake stage to the core
    typedef struct packed {
        logic fire;
        logic restart;
    } t_ctl;

    // one closed block
    typedef struct packed {
        logic               valid;
        logic [FIELD_W-1:0] x_start;
        logic [FIELD_W-1:0] x_end;
        logic [FIELD_W-1:0] y_start;
        logic [FIELD_W-1:0] y_end;
    } t_blk;

endpackage

>>> rtl/core/bibr_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bibr_pix_if / bibr_blk_if
// Valid/ready channels for pixels in and closed blocks out.
// ---------------------------------------------------------------------------
interface bibr_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel;
    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface bibr_blk_if;
    logic       valid;
    logic       ready;
    logic [9:0] x_start;
    logic [9:0] x_end;
    logic [9:0] y_start;
    logic [9:0] y_end;
    logic       last_of_run;
    modport source (output valid, output x_start, output x_end, output y_start,
                    output y_end, output last_of_run, input ready);
    modport sink   (input valid, input x_start, input x_end, input y_start,
                    input y_end, input last_of_run, output ready);
endinterface

>>> rtl/core/bibr_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bibr_ram
// Simple dual-port RAM, registered write-first read.
// ---------------------------------------------------------------------------
module bibr_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 512,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/core/bibr_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bibr_core
// Run detection and row-to-row run matching over two ping-pong run stores.
// ---------------------------------------------------------------------------
module bibr_core #(
    parameter int MAX_WIDTH  = bibr_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bibr_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_RUNS   = bibr_pkg::DEF_MAX_RUNS,
    localparam int CW  = $clog2(MAX_WIDTH),
    localparam int WW  = $clog2(MAX_WIDTH + 1),
    localparam int RW  = $clog2(MAX_HEIGHT + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bibr_pkg::t_ctl                i_ctl,
    input  logic [bibr_pkg::PIXEL_W-1:0]  i_pixel,
    input  logic [WW-1:0]                 i_width,
    input  logic [RW-1:0]                 i_height,
    output bibr_pkg::t_blk                o_blk,
    output logic [CW-1:0]                 o_column
);
    import bibr_pkg::*;

    localparam int NW = $clog2(MAX_RUNS + 1);
    localparam int AW = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
    localparam int EW = 2 * CW + RW;
    localparam logic [NW-1:0] RUNS_N = NW'(MAX_RUNS);

    logic [NW-1:0] r_prev_cnt, n_prev_cnt;
    logic [NW-1:0] r_cur_cnt,  n_cur_cnt;
    logic [NW-1:0] r_ptr,      n_ptr;
    logic [CW-1:0] r_col,      n_col;
    logic [RW-1:0] r_row,      n_row;
    logic          r_open,     n_open;
    logic [CW-1:0] r_begin,    n_begin;
    logic          r_bank,     n_bank;

    logic [EW-1:0] rd0, rd1, rd_prev, wr_data;
    logic [CW-1:0] pxs, pxe, cb, ce;
    logic [RW-1:0] pys, ys_new;
    logic          flush, fg, row_end, closing, have_prev, decide, room, matched, we;

    assign rd_prev         = r_bank ? rd1 : rd0;
    assign {pxs, pxe, pys} = rd_prev;

    always_comb begin
        flush   = (r_row >= i_height);
        fg      = !flush && (i_pixel != '0);
        row_end = ((CW+1)'(r_col) + (CW+1)'(1)) >= (CW+1)'(i_width);
        closing = 1'b0;
        cb      = r_begin;
        ce      = r_col;
        n_open  = r_open;
        n_begin = r_begin;
        if (fg) begin
            if (!r_open) begin
                n_open  = 1'b1;
                n_begin = r_col;
                cb      = r_col;
            end
            if (row_end) begin
                closing = 1'b1;
                n_open  = 1'b0;
            end
        end else if (r_open) begin
            closing = 1'b1;
            ce      = r_col - CW'(1);
            n_open  = 1'b0;
        end

        have_prev = (r_ptr < r_prev_cnt);
        decide    = have_prev &&
                    ((((CW+1)'(pxe) + (CW+1)'(1)) <= (CW+1)'(r_col)) ||
                     (row_end && (pxe <= r_col)));
        room      = (r_cur_cnt < RUNS_N);
        matched   = closing && (pxs == cb) && (pxe == ce) && room;
        ys_new    = (decide && matched) ? pys : r_row;
        we        = i_ctl.fire && closing && room;
        wr_data   = {cb, ce, ys_new};

        // block the pending pixel would close; the caller gates it with fire
        o_blk.valid   = decide && !matched;
        o_blk.x_start = FIELD_W'(pxs);
        o_blk.x_end   = FIELD_W'(pxe);
        o_blk.y_start = FIELD_W'(pys);
        o_blk.y_end   = FIELD_W'(r_row - RW'(1));

        n_prev_cnt = r_prev_cnt;
        n_cur_cnt  = r_cur_cnt;
        n_ptr      = r_ptr;
        n_col      = r_col;
        n_row      = r_row;
        n_bank     = r_bank;

        if (i_ctl.restart) begin
            n_prev_cnt = '0;
            n_cur_cnt  = '0;
            n_ptr      = '0;
            n_col      = '0;
            n_row      = '0;
            n_open     = 1'b0;
            n_begin    = '0;
            n_bank     = 1'b0;
        end else if (i_ctl.fire) begin
            if (decide) begin
                n_ptr = r_ptr + NW'(1);
            end
            if (we) begin
                n_cur_cnt = r_cur_cnt + NW'(1);
            end
            if (row_end) begin
                // swap banks: this row becomes the previous one
                n_prev_cnt = flush ? '0 : n_cur_cnt;
                n_cur_cnt  = '0;
                n_ptr      = '0;
                n_col      = '0;
                n_open     = 1'b0;
                n_bank     = !r_bank;
                n_row      = flush ? '0 : r_row + RW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end else begin
            n_open  = r_open;
            n_begin = r_begin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_cnt <= '0;
            r_cur_cnt  <= '0;
            r_ptr      <= '0;
            r_col      <= '0;
            r_row      <= '0;
            r_open     <= 1'b0;
            r_begin    <= '0;
            r_bank     <= 1'b0;
        end else begin
            r_prev_cnt <= n_prev_cnt;
            r_cur_cnt  <= n_cur_cnt;
            r_ptr      <= n_ptr;
            r_col      <= n_col;
            r_row      <= n_row;
            r_open     <= n_open;
            r_begin    <= n_begin;
            r_bank     <= n_bank;
        end
    end

    // both banks read at the next pointer; the previous-row bank is picked after
    bibr_ram #(.WIDTH(EW), .DEPTH(MAX_RUNS)) u_bank0 (
        .i_clk   (i_clk),
        .i_we    (we && r_bank),
        .i_waddr (r_cur_cnt[AW-1:0]),
        .i_wdata (wr_data),
        .i_raddr (n_ptr[AW-1:0]),
        .o_rdata (rd0)
    );

    bibr_ram #(.WIDTH(EW), .DEPTH(MAX_RUNS)) u_bank1 (
        .i_clk   (i_clk),
        .i_we    (we && !r_bank),
        .i_waddr (r_cur_cnt[AW-1:0]),
        .i_wdata (wr_data),
        .i_raddr (n_ptr[AW-1:0]),
        .o_rdata (rd1)
    );

    assign o_column = r_col;
endmodule

>>> rtl/core/binary_image_block_representation.sv
`timescale 1ns / 1ps
// A pixel transaction is registered in the input register when it is accepted; a block it
// closes is loaded into the result register when the core processes that pixel.
// Throughput: one pixel per cycle; a pixel waits only when it closes a block while the
// previous block waits downstream, or on a register write. Each pixel reads one stored run.
// Reset (i_rst_n low, synchronous) clears the stream position, run counts and the
// handshake stages; run stores need no clearing pass. A register write restarts the stream.
// ---------------------------------------------------------------------------
// binary_image_block_representation
// Streams a binary image and emits rectangular blocks built from repeated runs.
// ---------------------------------------------------------------------------
module binary_image_block_representation #(
    parameter int MAX_WIDTH  = bibr_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bibr_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_RUNS   = bibr_pkg::DEF_MAX_RUNS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    bibr_pix_if.sink                      i_pix,
    bibr_blk_if.source                    o_blk,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bibr_pkg::APB_AW-1:0]   paddr,
    input  logic [bibr_pkg::APB_DW-1:0]   pwdata,
    output logic [bibr_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import bibr_pkg::*;
    `include "binary_image_block_representation_macros.svh"

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 1);
    localparam int LW = (CFG_W > WW + 1) ? CFG_W : WW + 1;
    localparam int LH = (CFG_W > RW + 1) ? CFG_W : RW + 1;

    // ---- configuration port -------------------------------------------------
    logic [CFG_W-1:0] r_cfg_w, r_cfg_h;
    logic             cfg_write;
    logic             cfg_idx;
    logic [WW-1:0]    width_c;
    logic [RW-1:0]    height_c;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= RST_WIDTH;
            r_cfg_h <= RST_HEIGHT;
        end else if (cfg_write) begin
            case (cfg_idx)
                REG_WIDTH:  r_cfg_w <= pwdata[CFG_W-1:0];
                REG_HEIGHT: r_cfg_h <= pwdata[CFG_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_WIDTH:  prdata = APB_DW'(r_cfg_w);
            REG_HEIGHT: prdata = APB_DW'(r_cfg_h);
            default:    prdata = '0;
        endcase
    end

    // clamp the registers to the supported geometry, zero counts as one
    always_comb begin
        if (r_cfg_w == '0) begin
            width_c = WW'(1);
        end else if (LW'(r_cfg_w) > LW'(MAX_WIDTH)) begin
            width_c = WW'(MAX_WIDTH);
        end else begin
            width_c = WW'(r_cfg_w);
        end
        if (r_cfg_h == '0) begin
            height_c = RW'(1);
        end else if (LH'(r_cfg_h) > LH'(MAX_HEIGHT)) begin
            height_c = RW'(MAX_HEIGHT);
        end else begin
            height_c = RW'(r_cfg_h);
        end
    end

    // ---- input register -----------------------------------------------------
    // Hold one pixel; the core consumes it unless it closes a block while the
    // result register still holds one that has not been taken, or a register write occurs.
    logic               r_in_valid;
    logic [PIXEL_W-1:0] r_pixel;
    logic               r_out_valid;
    logic               out_load_ok;
    t_ctl               ctl;
    t_blk               blk;
    logic [CW-1:0]      column;

    assign out_load_ok = !r_out_valid || o_blk.ready;
    assign ctl.fire    = r_in_valid && (out_load_ok || !blk.valid) && !cfg_write;
    assign ctl.restart = cfg_write;
    assign i_pix.ready = !r_in_valid || ctl.fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_pix.ready) begin
            r_in_valid <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pix.valid && i_pix.ready) begin
            r_pixel <= i_pix.pixel;
        end
    end

    // ---- run matching core --------------------------------------------------
    bibr_core #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_RUNS   (MAX_RUNS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_pixel  (r_pixel),
        .i_width  (width_c),
        .i_height (height_c),
        .o_blk    (blk),
        .o_column (column)
    );

    // ---- result register ----------------------------------------------------
    // Load when a processed pixel closes a block; drop the valid once it is taken.
    t_blk r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl.fire && blk.valid) begin
            r_out_valid <= 1'b1;
        end else if (o_blk.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.fire && blk.valid) begin
            r_res <= blk;
        end
    end

    assign o_blk.valid       = r_out_valid;
    assign o_blk.x_start     = r_res.x_start;
    assign o_blk.x_end       = r_res.x_end;
    assign o_blk.y_start     = r_res.y_start;
    assign o_blk.y_end       = r_res.y_end;
    assign o_blk.last_of_run = 1'b1;

    // ---- checks -------------------------------------------------------------
    logic col_in_row;
    assign col_in_row = ((CW+1)'(column) < (CW+1)'(width_c)) || cfg_write;

    `BIBR_ASSERT_NOW(a_col_in_row, r_in_valid, col_in_row)
    `BIBR_ASSERT_NEXT(a_result_held, r_out_valid && !o_blk.ready, r_out_valid)
    `BIBR_ASSERT_NEXT(a_fire_loads, ctl.fire && blk.valid, r_out_valid)
endmodule

>>> dv/tb_binary_image_block_representation.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Block representation testbench
// Streams binary images through the block and checks every closed block. A
// scoreboard predicts the blocks from each accepted pixel, and each block the
// block sends out is compared with the oldest prediction. Both channels idle at
// random, and the image size registers are swept between images.
// ---------------------------------------------------------------------------
module tb_binary_image_block_representation;
    import bibr_pkg::*;

    localparam int CLK_HALF   = 4;
    localparam int WATCH_MAX  = 20000;
    localparam int DRAIN_WAIT = 8;

    typedef struct {
        int unsigned xs;
        int unsigned xe;
        int unsigned ys;
    } span_t;

    typedef struct {
        logic [FIELD_W-1:0] x_start;
        logic [FIELD_W-1:0] x_end;
        logic [FIELD_W-1:0] y_start;
        logic [FIELD_W-1:0] y_end;
        logic               last_of_run;
    } block_t;

    // Prediction of closed blocks from the pixel stream
    class block_scoreboard;
        block_t      pending_blocks[$];
        int unsigned errors;
        int unsigned blocks_seen;
        int unsigned images_done;
        int unsigned cfg_width;
        int unsigned cfg_height;
        span_t       upper_runs[DEF_MAX_RUNS];
        span_t       lower_runs[DEF_MAX_RUNS];
        int unsigned upper_count;
        int unsigned lower_count;
        int unsigned next_upper;
        int unsigned col;
        int unsigned row;
        bit          in_run;
        int unsigned run_first;

        function new();
            cfg_width  = DEF_MAX_WIDTH;
            cfg_height = DEF_MAX_HEIGHT;
            restart();
        endfunction

        function void restart();
            upper_count = 0;
            lower_count = 0;
            next_upper  = 0;
            col         = 0;
            row         = 0;
            in_run      = 0;
            run_first   = 0;
        endfunction

        function int unsigned clamp(int unsigned v, int unsigned hi);
            if (v < 1) begin
                return 1;
            end
            return (v > hi) ? hi : v;
        endfunction

        function void write_reg(logic idx, logic [CFG_W-1:0] value);
            if (idx == REG_WIDTH) begin
                cfg_width = value;
            end else begin
                cfg_height = value;
            end
            restart();
        endfunction

        // Advance the prediction by one accepted pixel
        function void note_pixel(logic [PIXEL_W-1:0] px);
            int unsigned w, h, c, cb, ce, ys, pxe;
            bit          flush, fg, row_end, closing, matched;
            block_t      b;
            w       = clamp(cfg_width, DEF_MAX_WIDTH);
            h       = clamp(cfg_height, DEF_MAX_HEIGHT);
            c       = col;
            flush   = row >= h;
            fg      = !flush && px != 0;
            row_end = (c + 1) >= w;
            closing = 0;
            cb      = 0;
            ce      = 0;
            ys      = row;
            if (fg) begin
                if (!in_run) begin
                    in_run    = 1;
                    run_first = c;
                end
                if (row_end) begin
                    closing = 1;
                    cb      = run_first;
                    ce      = c;
                    in_run  = 0;
                end
            end else if (in_run) begin
                closing = 1;
                cb      = run_first;
                ce      = c - 1;
                in_run  = 0;
            end
            // decide the oldest undecided run of the row above once it is past
            if (next_upper < upper_count && next_upper < DEF_MAX_RUNS) begin
                pxe = upper_runs[next_upper].xe;
                if (pxe + 1 <= c || (row_end && pxe <= c)) begin
                    matched = closing && upper_runs[next_upper].xs == cb && pxe == ce
                              && lower_count < DEF_MAX_RUNS;
                    if (matched) begin
                        ys = upper_runs[next_upper].ys;
                    end else begin
                        b.x_start     = FIELD_W'(upper_runs[next_upper].xs);
                        b.x_end       = FIELD_W'(pxe);
                        b.y_start     = FIELD_W'(upper_runs[next_upper].ys);
                        b.y_end       = FIELD_W'(row - 1);
                        b.last_of_run = 1'b1;
                        pending_blocks.push_back(b);
                    end
                    next_upper++;
                end
            end
            if (closing && lower_count < DEF_MAX_RUNS) begin
                lower_runs[lower_count].xs = cb;
                lower_runs[lower_count].xe = ce;
                lower_runs[lower_count].ys = ys;
                lower_count++;
            end
            if (row_end) begin
                for (int i = 0; i < lower_count; i++) begin
                    upper_runs[i] = lower_runs[i];
                end
                upper_count = lower_count;
                lower_count = 0;
                next_upper  = 0;
                col         = 0;
                in_run      = 0;
                if (flush) begin
                    row         = 0;
                    upper_count = 0;
                    images_done++;
                end else begin
                    row++;
                end
            end else begin
                col = c + 1;
            end
        endfunction

        function void report(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            errors++;
        endfunction

        // Compare one block transaction with the oldest prediction
        function void check_block(block_t got);
            block_t want;
            blocks_seen++;
            if (pending_blocks.size() == 0) begin
                report($sformatf("unexpected block x %0d..%0d y %0d..%0d",
                                 got.x_start, got.x_end, got.y_start, got.y_end));
                return;
            end
            want = pending_blocks.pop_front();
            if (got.x_start !== want.x_start)
                report($sformatf("x_start %0d, want %0d", got.x_start, want.x_start));
            if (got.x_end !== want.x_end)
                report($sformatf("x_end %0d, want %0d", got.x_end, want.x_end));
            if (got.y_start !== want.y_start)
                report($sformatf("y_start %0d, want %0d", got.y_start, want.y_start));
            if (got.y_end !== want.y_end)
                report($sformatf("y_end %0d, want %0d", got.y_end, want.y_end));
            if (got.last_of_run !== want.last_of_run)
                report($sformatf("last_of_run %0b, want %0b", got.last_of_run,
                                 want.last_of_run));
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [APB_AW-1:0]  paddr;
    logic [APB_DW-1:0]  pwdata;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    bibr_pix_if pix ();
    bibr_blk_if blk ();

    binary_image_block_representation dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix),
        .o_blk   (blk),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    block_scoreboard sb = new();

    int unsigned pixels_sent;
    int unsigned burst_left;
    int unsigned idle_cycles;
    int unsigned stall_phase;
    bit          stall_mode;
    bit          activity;

    always begin
        i_clk = 1'b1;
        #CLK_HALF;
        i_clk = 1'b0;
        #CLK_HALF;
    end

    // Receiver: alternate stretches of steady acceptance with random stalls
    always @(negedge i_clk) begin
        stall_phase <= stall_phase + 1;
        if (stall_phase % 96 == 0) begin
            stall_mode <= ~stall_mode;
        end
        blk.ready <= stall_mode ? ($urandom_range(0, 3) != 0) : 1'b1;
    end

    // Sample block transactions at the rising edge
    always @(posedge i_clk) begin
        block_t got;
        if (i_rst_n && blk.valid && blk.ready) begin
            got.x_start     = blk.x_start;
            got.x_end       = blk.x_end;
            got.y_start     = blk.y_start;
            got.y_end       = blk.y_end;
            got.last_of_run = blk.last_of_run;
            sb.check_block(got);
        end
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge i_clk) begin
        if (activity || (blk.valid && blk.ready) || (pix.valid && pix.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCH_MAX) begin
            $display("watchdog expired after %0d quiet cycles", idle_cycles);
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Hold until every predicted block has come out, then let the pipe settle
    task automatic drain();
        while (sb.pending_blocks.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // Write one register, then read it back
    task automatic write_reg(logic idx, int unsigned value);
        drain();
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = APB_AW'({idx, 2'b00});
        pwdata  = APB_DW'(value);
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.write_reg(idx, CFG_W'(value));
        activity = 1'b1;
        @(negedge i_clk);
        activity = 1'b0;
        pwrite   = 1'b0;
        penable  = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata[CFG_W-1:0] !== CFG_W'(value))
            sb.report($sformatf("register %0d reads %0h, want %0h", idx,
                                prdata[CFG_W-1:0], CFG_W'(value)));
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic set_size(int unsigned w, int unsigned h);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
    endtask

    // Send one pixel; bursts of random length are separated by random gaps
    task automatic send_pixel(logic [PIXEL_W-1:0] px);
        if (burst_left == 0) begin
            int unsigned gap;
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                @(negedge i_clk);
                pix.valid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        @(negedge i_clk);
        pix.valid = 1'b1;
        pix.pixel = px;
        @(posedge i_clk);
        while (!pix.ready) @(posedge i_clk);
        sb.note_pixel(px);
        pixels_sent++;
    endtask

    task automatic stop_sending();
        @(negedge i_clk);
        pix.valid = 1'b0;
        burst_left = 0;
    endtask

    // Send rows of an image, rows at or past its height as random flush rows; rows mostly repeat
    // the one above so that blocks grow over several rows
    task automatic send_image(int unsigned w, int unsigned h, int unsigned rows);
        bit [DEF_MAX_WIDTH-1:0] mask;
        int unsigned            density;
        mask = '0;
        for (int r = 0; r < rows; r++) begin
            if (r == 0 || $urandom_range(0, 9) < 4) begin
                density = $urandom_range(1, 9);
                for (int x = 0; x < w; x++) begin
                    mask[x] = $urandom_range(0, 9) < density;
                end
            end
            for (int x = 0; x < w; x++) begin
                if (r >= h) begin
                    send_pixel(8'($urandom_range(0, 255)));
                end else begin
                    send_pixel(mask[x] ? 8'($urandom_range(1, 255)) : 8'h00);
                end
            end
        end
    endtask

    initial begin
        int unsigned w, h;
        i_rst_n     = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        pix.valid   = 1'b0;
        pix.pixel   = '0;
        blk.ready   = 1'b0;
        stall_phase = 0;
        stall_mode  = 1'b0;
        idle_cycles = 0;
        activity    = 1'b0;
        burst_left  = 0;
        pixels_sent = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // 4x3 image: a 2x2 block, a run that changes, values touching each bit
        set_size(4, 3);
        send_pixel(8'h00); send_pixel(8'hFF); send_pixel(8'h01); send_pixel(8'h00);
        send_pixel(8'h00); send_pixel(8'h80); send_pixel(8'h7F); send_pixel(8'h00);
        send_pixel(8'h55); send_pixel(8'hAA); send_pixel(8'h00); send_pixel(8'h02);
        send_pixel(8'hFF); send_pixel(8'h00); send_pixel(8'hFF); send_pixel(8'h00);
        // restart mid-image: open blocks are dropped
        send_pixel(8'h10); send_pixel(8'h20);
        stop_sending();
        // clamped extremes: zero width and height become one
        set_size(0, 0);
        repeat (6) send_pixel(8'($urandom_range(0, 255)));
        stop_sending();
        // width beyond range clamps to the full row; stream part of one row
        set_size(2047, 1);
        repeat (150) send_pixel(($urandom_range(0, 3) == 0) ? 8'h00 : 8'hFF);
        stop_sending();
        set_size(2, DEF_MAX_HEIGHT);
        send_image(2, 5, 5);
        stop_sending();

        // random images, mostly small
        while (pixels_sent < 800) begin
            w = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 12);
            h = $urandom_range(1, 8);
            set_size(w, h);
            repeat ($urandom_range(1, 3)) send_image(w, h, h + 1);
            if ($urandom_range(0, 3) == 0) begin
                send_image(w, h, $urandom_range(1, h));
            end
            stop_sending();
            if ($urandom_range(0, 5) == 0) begin
                drain();
            end
        end

        drain();
        repeat (20) @(posedge i_clk);
        $display("sent %0d pixels over %0d complete images, checked %0d blocks",
                 pixels_sent, sb.images_done, sb.blocks_seen);
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("FAIL");
        end
        $finish;
    end

endmodule
